### hw/rtl/midi_key_debouncer_assert.svh
// Assertion macros used by the checker file
`ifndef MIDI_KEY_DEBOUNCER_ASSERT_SVH
`define MIDI_KEY_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MKD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mkd_pkg.sv
package mkd_pkg;

  // Sizes
  localparam int MAX_STEPS   = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int STEPS_W     = 7;
  localparam int CHAN_W      = 5;
  localparam int NOTE_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  // MIDI command codes (high nibble carries the command)
  localparam logic [BYTE_W-1:0] CMD_ON   = 8'h90;
  localparam logic [BYTE_W-1:0] CMD_OFF  = 8'h80;
  localparam logic [BYTE_W-1:0] MSG_SIZE = 8'd3;

  // Item kinds
  localparam logic OP_MIDI = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIDI_CHANNEL   = 4'd0,
    REG_BASE_NOTE      = 4'd1,
    REG_PERIOD_SAMPLES = 4'd2,
    REG_DEBOUNCE_STEPS = 4'd3
  } cfg_reg_t;

  // One outgoing message
  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [NOTE_W-1:0] note;
    logic              last;
  } res_t;

endpackage

### hw/rtl/mkd_if.sv
// Input channel: MIDI event or sample tick
interface mkd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [mkd_pkg::BYTE_W-1:0] msg_size;
  logic [mkd_pkg::BYTE_W-1:0] status_byte;
  logic [mkd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, op, msg_size, status_byte, data_byte, input ready);
  modport sink   (input valid, op, msg_size, status_byte, data_byte, output ready);
endinterface

// Result channel: note on/off messages
interface mkd_out_if;
  logic                      valid;
  logic                      ready;
  logic [mkd_pkg::BYTE_W-1:0] out_status;
  logic [mkd_pkg::NOTE_W-1:0] out_note;
  logic                      out_last;

  modport source (output valid, out_status, out_note, out_last, input ready);
  modport sink   (input valid, out_status, out_note, out_last, output ready);
endinterface

// Configuration write channel
interface mkd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mkd_pkg::CFG_IDX_W-1:0]  index;
  logic [mkd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/midi_key_debouncer.sv
// Channel   Dir  Payload
// in_ch     in   op, msg_size, status_byte, data_byte
// out_ch    out  out_status, out_note, out_last
// cfg_ch    in   index, data (4 registers, always ready)
//
// One item per cycle: an item is held in the input register, then is
// worked out and its messages land in a two-entry result queue feeding out_ch.
// A tick that flips a contact holds the input register until the queue has room.
// The path from input transfer to first message on out_ch: input register, result queue.
// Synchronous active-low reset clears contacts, histories, prescaler, queue
// and loads register defaults; no clearing pass is needed.
module midi_key_debouncer (
  input  logic clk,
  input  logic rst_n,
  mkd_in_if.sink    in_ch,
  mkd_out_if.source out_ch,
  mkd_cfg_if.sink   cfg_ch
);
  import mkd_pkg::*;

  // Configuration registers
  logic [CHAN_W-1:0]      midi_channel_r;
  logic [NOTE_W-1:0]      base_note_r;
  logic [COUNT_WIDTH-1:0] period_samples_r;
  logic [STEPS_W-1:0]     debounce_steps_r;

  // Input register
  logic              in_vld_r;
  logic              op_r;
  logic [BYTE_W-1:0] size_r;
  logic [BYTE_W-1:0] status_r;
  logic [BYTE_W-1:0] data_r;

  // Block state
  logic                   raw_dit_r, raw_dah_r;
  logic                   clean_dit_r, clean_dah_r;
  logic [COUNT_WIDTH-1:0] countdown_r;
  logic [MAX_STEPS-1:0]   dit_hist_r, dah_hist_r;

  // Result queue
  res_t       q_r [QUEUE_DEPTH];
  logic [1:0] cnt_r;

  // Combinational
  logic                   in_xfer, pop, fire;
  logic                   chan_hit, dit_hit, dah_hit, is_on, is_off;
  logic                   raw_dit_nxt, raw_dah_nxt;
  logic                   do_sample;
  logic [STEPS_W-1:0]     steps_eff;
  logic [MAX_STEPS-1:0]   win_mask;
  logic [MAX_STEPS-1:0]   dit_hist_nxt, dah_hist_nxt;
  logic                   flip_dit, flip_dah;
  logic [1:0]             n_push, cnt_pop;
  logic [3:0]             chan_out;
  logic [NOTE_W-1:0]      dah_note;
  res_t                   dit_res, dah_res, res0, res1;

  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign pop          = out_ch.valid && out_ch.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      midi_channel_r   <= CHAN_W'(1);
      base_note_r      <= '0;
      period_samples_r <= COUNT_WIDTH'(240);
      debounce_steps_r <= STEPS_W'(32);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIDI_CHANNEL:   midi_channel_r   <= cfg_ch.data[CHAN_W-1:0];
        REG_BASE_NOTE:      base_note_r      <= cfg_ch.data[NOTE_W-1:0];
        REG_PERIOD_SAMPLES: period_samples_r <= cfg_ch.data[COUNT_WIDTH-1:0];
        REG_DEBOUNCE_STEPS: debounce_steps_r <= cfg_ch.data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // MIDI decode
  assign chan_hit = (size_r == MSG_SIZE) &&
                    ((CHAN_W'(status_r[3:0]) + CHAN_W'(1)) == midi_channel_r);
  assign dit_hit  = chan_hit && (data_r == {1'b0, base_note_r});
  assign dah_hit  = chan_hit && !dit_hit &&
                    (data_r == ({1'b0, base_note_r} + BYTE_W'(1)));
  assign is_on    = status_r[7:4] == CMD_ON[7:4];
  assign is_off   = status_r[7:4] == CMD_OFF[7:4];

  always_comb begin
    raw_dit_nxt = raw_dit_r;
    raw_dah_nxt = raw_dah_r;
    if (dit_hit && is_on)  raw_dit_nxt = 1'b1;
    if (dit_hit && is_off) raw_dit_nxt = 1'b0;
    if (dah_hit && is_on)  raw_dah_nxt = 1'b1;
    if (dah_hit && is_off) raw_dah_nxt = 1'b0;
  end

  // Window mask from the clamped step count
  always_comb begin
    steps_eff = debounce_steps_r;
    if (debounce_steps_r == '0) steps_eff = STEPS_W'(1);
    if (debounce_steps_r > STEPS_W'(MAX_STEPS)) steps_eff = STEPS_W'(MAX_STEPS);
    win_mask = {MAX_STEPS{1'b1}} >> (STEPS_W'(MAX_STEPS) - steps_eff);
  end

  // Sampling: shift raw levels in, check the window for all ones / all zeros
  assign do_sample    = (op_r == OP_TICK) && (countdown_r <= COUNT_WIDTH'(1));
  assign dit_hist_nxt = {dit_hist_r[MAX_STEPS-2:0], raw_dit_r};
  assign dah_hist_nxt = {dah_hist_r[MAX_STEPS-2:0], raw_dah_r};
  assign flip_dit = do_sample && (clean_dit_r ? ~|(dit_hist_nxt & win_mask)
                                              : &(dit_hist_nxt | ~win_mask));
  assign flip_dah = do_sample && (clean_dah_r ? ~|(dah_hist_nxt & win_mask)
                                              : &(dah_hist_nxt | ~win_mask));

  // Message build; dit goes first
  assign chan_out = 4'(midi_channel_r - CHAN_W'(1));
  assign dah_note = base_note_r + NOTE_W'(1);
  assign dit_res  = '{status: (clean_dit_r ? CMD_OFF : CMD_ON) | {4'h0, chan_out},
                      note: base_note_r, last: !flip_dah};
  assign dah_res  = '{status: (clean_dah_r ? CMD_OFF : CMD_ON) | {4'h0, chan_out},
                      note: dah_note, last: 1'b1};
  assign res0     = flip_dit ? dit_res : dah_res;
  assign res1     = dah_res;
  assign n_push   = {1'b0, flip_dit} + {1'b0, flip_dah};

  // Work the held item once the queue has room for its messages
  assign fire        = in_vld_r &&
                       (({1'b0, cnt_r} + {1'b0, n_push}) <= 3'(QUEUE_DEPTH));
  assign in_ch.ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.op;
      size_r   <= in_ch.msg_size;
      status_r <= in_ch.status_byte;
      data_r   <= in_ch.data_byte;
    end
  end

  // Contact, history and prescaler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_dit_r   <= 1'b0;
      raw_dah_r   <= 1'b0;
      clean_dit_r <= 1'b0;
      clean_dah_r <= 1'b0;
      countdown_r <= '0;
      dit_hist_r  <= '0;
      dah_hist_r  <= '0;
    end else if (fire) begin
      if (op_r == OP_MIDI) begin
        raw_dit_r <= raw_dit_nxt;
        raw_dah_r <= raw_dah_nxt;
      end else if (do_sample) begin
        countdown_r <= period_samples_r;
        dit_hist_r  <= dit_hist_nxt;
        dah_hist_r  <= dah_hist_nxt;
        if (flip_dit) clean_dit_r <= !clean_dit_r;
        if (flip_dah) clean_dah_r <= !clean_dah_r;
      end else begin
        countdown_r <= countdown_r - COUNT_WIDTH'(1);
      end
    end
  end

  // Result queue: slot 0 is the head, pop shifts slot 1 down
  assign cnt_pop = cnt_r - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_pop + (fire ? n_push : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_pop)
      2'd0: begin
        q_r[0] <= res0;
        q_r[1] <= res1;
      end
      2'd1: begin
        if (pop) q_r[0] <= q_r[1];
        q_r[1] <= res0;
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.out_status = q_r[0].status;
  assign out_ch.out_note   = q_r[0].note;
  assign out_ch.out_last   = q_r[0].last;

endmodule

### hw/rtl/mkd_checker.sv
`include "midi_key_debouncer_assert.svh"

module mkd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mkd_pkg::BYTE_W-1:0] out_status,
  input logic [mkd_pkg::NOTE_W-1:0] out_note,
  input logic                      out_last
);

  // Stalled result holds its payload
  `MKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_note) && $stable(out_last), "stalled result changed")

  // Right after reset: nothing queued, input open
  `MKD_ASSERT_SAME(a_reset_quiet, clk, rst_n, $past(!rst_n), !out_valid && in_ready, "block not idle after reset")

  // A dit message that is not last is followed at once by the dah message
  `MKD_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !out_last, out_valid && out_last && (out_note == $past(out_note) + 7'd1), "dah message missing after dit")

endmodule

bind midi_key_debouncer mkd_checker u_mkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.out_status),
  .out_note   (out_ch.out_note),
  .out_last   (out_ch.out_last)
);
